// ===== design/mmcs_pkg.sv =====
// Shared types, constants and register indexes for the min-max contrast stretch block.
`default_nettype none
package mmcs_pkg;

	// pixel value width once sign or zero extended, and default pixel width
	localparam int VAL_W = 33;
	localparam int PIXEL_BITS_DEF = 32;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 33;

	localparam logic [CFG_IDX_W-1:0] REG_OVR_EN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVR_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OVR_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IGN_EN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IGN_LVL  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PIX_SGN  = 3'd5;

	// running statistics restart values
	localparam logic [VAL_W-1:0] STAT_MAX = 33'h0_FFFF_FFFF;
	localparam logic [VAL_W-1:0] STAT_MIN = 33'h1_0000_0000;

	// restoring divider: 8 quotient bits, one per cycle
	localparam int DIV_STEPS = 8;
	localparam int CNT_W = 3;
	localparam int REM_W = VAL_W + DIV_STEPS;

	// job queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef struct packed {
		logic        func;
		logic [31:0] pixel_bits;
		logic        last_in_pass;
	} in_word_t;

	typedef struct packed {
		logic [7:0] scaled_pixel;
		logic       flat_range;
		logic       last_out;
	} out_word_t;

	typedef struct packed {
		logic             ovr_en;
		logic [VAL_W-1:0] ovr_low;
		logic [VAL_W-1:0] ovr_high;
		logic             ign_en;
		logic [VAL_W-1:0] ign_level;
		logic             pix_signed;
	} cfg_t;

	typedef enum logic [1:0] {
		JOB_FLAT,
		JOB_ZERO,
		JOB_SAT,
		JOB_DIV
	} job_kind_t;

	typedef struct packed {
		job_kind_t        kind;
		logic [VAL_W-1:0] diff;
		logic [VAL_W-1:0] den;
		logic             last;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} back_state_t;

endpackage
`default_nettype wire

// ===== design/mmcs_csr.sv =====
// Configuration registers written through the plain write port.
`default_nettype none
module mmcs_csr (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wen,
	input  wire logic [mmcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mmcs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output mmcs_pkg::cfg_t                        cfg
);

	mmcs_pkg::cfg_t cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ovr_en     <= 1'b0;
			cfg_q.ovr_low    <= '0;
			cfg_q.ovr_high   <= mmcs_pkg::VAL_W'(255);
			cfg_q.ign_en     <= 1'b0;
			cfg_q.ign_level  <= '0;
			cfg_q.pix_signed <= 1'b1;
		end else if (cfg_wen) begin
			case (cfg_index)
				mmcs_pkg::REG_OVR_EN:   cfg_q.ovr_en     <= cfg_data[0];
				mmcs_pkg::REG_OVR_LOW:  cfg_q.ovr_low    <= cfg_data;
				mmcs_pkg::REG_OVR_HIGH: cfg_q.ovr_high   <= cfg_data;
				mmcs_pkg::REG_IGN_EN:   cfg_q.ign_en     <= cfg_data[0];
				mmcs_pkg::REG_IGN_LVL:  cfg_q.ign_level  <= cfg_data;
				mmcs_pkg::REG_PIX_SGN:  cfg_q.pix_signed <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== design/mmcs_front.sv =====
// Front end: accepts words, tracks min/max, classifies scale pixels into jobs.
`default_nettype none
module mmcs_front #(
	parameter int PIXEL_BITS = mmcs_pkg::PIXEL_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mmcs_pkg::cfg_t     cfg,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire mmcs_pkg::in_word_t in_word,
	input  wire logic               q_full,
	output logic                    q_push,
	output mmcs_pkg::job_t          q_job
);

	localparam int VW = mmcs_pkg::VAL_W;

	logic                  accept;
	logic [PIXEL_BITS-1:0] raw;
	logic                  sign;
	logic signed [VW-1:0]  pix;
	logic signed [VW-1:0]  low_q, high_q;
	logic                  fresh_q;
	logic signed [VW-1:0]  eff_low, eff_high;
	logic                  track;
	logic signed [VW-1:0]  lo, hi;
	logic signed [VW:0]    diff_w, den_w;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// pixel extraction at the configured width and signedness
	assign raw  = in_word.pixel_bits[PIXEL_BITS-1:0];
	assign sign = cfg.pix_signed & raw[PIXEL_BITS-1];
	assign pix  = $signed({{(VW-PIXEL_BITS){sign}}, raw});

	// statistics: a fresh frame restarts from the extreme values
	assign eff_low  = fresh_q ? $signed(mmcs_pkg::STAT_MAX) : low_q;
	assign eff_high = fresh_q ? $signed(mmcs_pkg::STAT_MIN) : high_q;
	assign track    = !(cfg.ign_en && (pix == $signed(cfg.ign_level)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= $signed(mmcs_pkg::STAT_MAX);
			high_q  <= $signed(mmcs_pkg::STAT_MIN);
			fresh_q <= 1'b1;
		end else if (accept) begin
			if (!in_word.func) begin
				low_q   <= (track && (pix < eff_low)) ? pix : eff_low;
				high_q  <= (track && (pix > eff_high)) ? pix : eff_high;
				fresh_q <= in_word.last_in_pass;
			end else begin
				fresh_q <= 1'b1;
			end
		end
	end

	// scale pass: pick bounds and classify
	assign lo     = cfg.ovr_en ? $signed(cfg.ovr_low) : low_q;
	assign hi     = cfg.ovr_en ? $signed(cfg.ovr_high) : high_q;
	assign diff_w = {pix[VW-1], pix} - {lo[VW-1], lo};
	assign den_w  = {hi[VW-1], hi} - {lo[VW-1], lo};

	always_comb begin
		q_job.diff = diff_w[VW-1:0];
		q_job.den  = den_w[VW-1:0];
		q_job.last = in_word.last_in_pass;
		if (hi <= lo)
			q_job.kind = mmcs_pkg::JOB_FLAT;
		else if (pix <= lo)
			q_job.kind = mmcs_pkg::JOB_ZERO;
		else if (pix >= hi)
			q_job.kind = mmcs_pkg::JOB_SAT;
		else
			q_job.kind = mmcs_pkg::JOB_DIV;
	end

	assign q_push = accept && in_word.func;

endmodule
`default_nettype wire

// ===== design/mmcs_queue.sv =====
// Short job queue between front and back.
`default_nettype none
module mmcs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mmcs_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                not_empty,
	output mmcs_pkg::job_t      head
);

	mmcs_pkg::job_t                   slot_q [mmcs_pkg::Q_DEPTH];
	logic [mmcs_pkg::Q_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [mmcs_pkg::Q_CNT_W-1:0]     count_q;

	assign full      = (count_q == mmcs_pkg::Q_CNT_W'(mmcs_pkg::Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== design/mmcs_back.sv =====
// Back end: restoring divider for 255*(p-lo)/(hi-lo) and the output register.
`default_nettype none
module mmcs_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	input  wire mmcs_pkg::job_t job,
	output logic                job_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output mmcs_pkg::out_word_t out_word
);

	localparam int RW = mmcs_pkg::REM_W;

	mmcs_pkg::back_state_t      state_q, state_d;
	logic [RW-1:0]              rem_q, dsr_q;
	logic [mmcs_pkg::CNT_W-1:0] cnt_q;
	logic [7:0]                 quo_q;
	logic                       flat_q, last_q;
	logic                       ge;
	logic                       is_div;

	assign is_div = (job.kind == mmcs_pkg::JOB_DIV);
	assign ge     = (rem_q >= dsr_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mmcs_pkg::ST_IDLE:
				if (job_valid)
					state_d = is_div ? mmcs_pkg::ST_DIV : mmcs_pkg::ST_DONE;
			mmcs_pkg::ST_DIV:
				if (cnt_q == '0)
					state_d = mmcs_pkg::ST_DONE;
			mmcs_pkg::ST_DONE:
				if (out_ready)
					state_d = mmcs_pkg::ST_IDLE;
			default:
				state_d = mmcs_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		job_pop   = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			mmcs_pkg::ST_IDLE: job_pop   = job_valid;
			mmcs_pkg::ST_DONE: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mmcs_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// datapath: load on pop, one quotient bit per cycle in ST_DIV
	always_ff @(posedge clk) begin
		if (job_pop) begin
			rem_q  <= {job.diff, 8'b0} - {8'b0, job.diff};
			dsr_q  <= {1'b0, job.den, (mmcs_pkg::DIV_STEPS-1)'(0)};
			cnt_q  <= mmcs_pkg::CNT_W'(mmcs_pkg::DIV_STEPS - 1);
			flat_q <= (job.kind == mmcs_pkg::JOB_FLAT);
			last_q <= job.last;
			case (job.kind)
				mmcs_pkg::JOB_SAT: quo_q <= 8'hFF;
				default:           quo_q <= 8'h00;
			endcase
		end else if (state_q == mmcs_pkg::ST_DIV) begin
			if (ge)
				rem_q <= rem_q - dsr_q;
			dsr_q <= dsr_q >> 1;
			quo_q <= {quo_q[6:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign out_word.scaled_pixel = quo_q;
	assign out_word.flat_range   = flat_q;
	assign out_word.last_out     = last_q;

endmodule
`default_nettype wire

// ===== design/minmax_contrast_stretch_core.sv =====
// A scale word is queued, popped by the back end and held in its output register when flat or
// clamped; a divided word first runs the 8-step restoring divider, one quotient bit a cycle.
// Throughput: statistics words 1 per cycle while the job queue has room; the back end takes a
// new scale job only once the last result was taken; a 2-entry queue decouples both.
// Reset (arst_n low): registers return to their defaults, queue empties, statistics restart.
// Top level: config registers, front end, job queue, divider back end.
`default_nettype none
module minmax_contrast_stretch_core #(
	parameter int PIXEL_BITS = mmcs_pkg::PIXEL_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wen,
	input  wire logic [mmcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mmcs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire mmcs_pkg::in_word_t               in_word,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output mmcs_pkg::out_word_t                   out_word
);

	mmcs_pkg::cfg_t cfg;
	mmcs_pkg::job_t push_job, head_job;
	logic           q_full, q_push, q_pop, q_not_empty;

	mmcs_csr u_csr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mmcs_front #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	mmcs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_job)
	);

	mmcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_not_empty),
		.job       (head_job),
		.job_pop   (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule
`default_nettype wire

// ===== design/mmcs_checker.sv =====
// Port-level checks for the contrast stretch core, bound to the top level.
`default_nettype none
module mmcs_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire mmcs_pkg::out_word_t out_word
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// flat range forces a zero pixel
	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.flat_range |-> out_word.scaled_pixel == 8'd0)
		else $error("flat range with nonzero pixel");

	// each result is shown once: the output drops after a taken word
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("output valid right after a taken word");

endmodule

bind minmax_contrast_stretch_core mmcs_checker u_mmcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for minmax_contrast_stretch_core: two-pass frames against a predictor.
`timescale 1ns / 100ps
module tb;

	// Mirrors the block: registers, running statistics and the bytes still due
	class stretch_checker;
		bit ovr_en;
		bit ign_en;
		bit pix_signed;
		bit fresh;
		logic signed [mmcs_pkg::VAL_W-1:0] ovr_low;
		logic signed [mmcs_pkg::VAL_W-1:0] ovr_high;
		logic signed [mmcs_pkg::VAL_W-1:0] ign_level;
		logic signed [mmcs_pkg::VAL_W-1:0] run_low;
		logic signed [mmcs_pkg::VAL_W-1:0] run_high;
		mmcs_pkg::out_word_t due[$];
		int fails;

		function new();
			ovr_en = 1'b0;
			ovr_low = '0;
			ovr_high = 33'sd255;
			ign_en = 1'b0;
			ign_level = '0;
			pix_signed = 1'b1;
			run_low = mmcs_pkg::STAT_MAX;
			run_high = mmcs_pkg::STAT_MIN;
			fresh = 1'b1;
			fails = 0;
		endfunction

		function void write_reg(logic [mmcs_pkg::CFG_IDX_W-1:0] idx,
				logic [mmcs_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				mmcs_pkg::REG_OVR_EN: ovr_en = data[0];
				mmcs_pkg::REG_OVR_LOW: ovr_low = data;
				mmcs_pkg::REG_OVR_HIGH: ovr_high = data;
				mmcs_pkg::REG_IGN_EN: ign_en = data[0];
				mmcs_pkg::REG_IGN_LVL: ign_level = data;
				mmcs_pkg::REG_PIX_SGN: pix_signed = data[0];
				default: ;
			endcase
		endfunction

		// statistics words update min/max, scale words queue an expected byte
		function void note_pixel(mmcs_pkg::in_word_t w);
			logic signed [mmcs_pkg::VAL_W-1:0] p;
			logic signed [mmcs_pkg::VAL_W-1:0] lo;
			logic signed [mmcs_pkg::VAL_W-1:0] hi;
			longint num;
			longint den;
			longint q;
			mmcs_pkg::out_word_t e;
			p = pix_signed ? {w.pixel_bits[31], w.pixel_bits} : {1'b0, w.pixel_bits};
			if (w.func == 1'b0) begin
				if (fresh) begin
					run_low = mmcs_pkg::STAT_MAX;
					run_high = mmcs_pkg::STAT_MIN;
					fresh = 1'b0;
				end
				if (!(ign_en && p == ign_level)) begin
					if (p < run_low)
						run_low = p;
					if (p > run_high)
						run_high = p;
				end
				if (w.last_in_pass)
					fresh = 1'b1;
				return;
			end
			lo = ovr_en ? ovr_low : run_low;
			hi = ovr_en ? ovr_high : run_high;
			e = '0;
			e.last_out = w.last_in_pass;
			if (hi <= lo) begin
				e.flat_range = 1'b1;
			end else if (p > lo) begin
				num = (longint'(p) - longint'(lo)) * 255;
				den = longint'(hi) - longint'(lo);
				q = num / den;
				e.scaled_pixel = (q > 255) ? 8'd255 : q[7:0];
			end
			fresh = 1'b1;
			due.push_back(e);
		endfunction

		function void check_byte(mmcs_pkg::out_word_t got);
			mmcs_pkg::out_word_t e;
			if (due.size() == 0) begin
				$error("unexpected output word: scaled_pixel %0d flat_range %0d last_out %0d",
					got.scaled_pixel, got.flat_range, got.last_out);
				fails++;
				return;
			end
			e = due.pop_front();
			if (got.scaled_pixel !== e.scaled_pixel) begin
				$error("scaled_pixel: expected %0d, got %0d", e.scaled_pixel, got.scaled_pixel);
				fails++;
			end
			if (got.flat_range !== e.flat_range) begin
				$error("flat_range: expected %0d, got %0d", e.flat_range, got.flat_range);
				fails++;
			end
			if (got.last_out !== e.last_out) begin
				$error("last_out: expected %0d, got %0d", e.last_out, got.last_out);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [mmcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mmcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	mmcs_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	mmcs_pkg::out_word_t out_word;

	stretch_checker chk = new();

	// current frame shape: pixel window and the raw value used as ignore level
	logic [31:0] base = '0;
	logic [31:0] span = '0;
	logic [31:0] ign_raw = '0;
	int burst_left = 0;
	int words_sent = 0;

	minmax_contrast_stretch_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: the stall pattern switches between modes at random
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		forever @(negedge clk) begin
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 4) == 0);
				default: out_ready <= ((left % 16) < 11);
			endcase
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			chk.check_byte(out_word);
	end

	// send one word; the sender sometimes idles between bursts of random length
	task automatic push_word(input logic f, input logic [31:0] bits, input logic lst);
		mmcs_pkg::in_word_t w;
		int gap;
		w.func = f;
		w.pixel_bits = bits;
		w.last_in_pass = lst;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		chk.note_pixel(w);
		burst_left--;
		words_sent++;
	endtask

	// stop sending and let the block go idle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (chk.due.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [mmcs_pkg::CFG_IDX_W-1:0] idx,
			input logic [mmcs_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		chk.write_reg(idx, data);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// pick a new pixel window and program all registers around it
	task automatic new_setting();
		bit sgn;
		logic [31:0] low_raw;
		logic [32:0] low_v;
		logic [32:0] high_v;
		int k;
		k = $urandom_range(0, 32);
		span = (k == 32) ? 32'hFFFF_FFFF : (32'd1 << k) - 32'd1;
		base = $urandom;
		ign_raw = base + $urandom_range(0, span);
		sgn = $urandom_range(0, 1);
		low_raw = base + $urandom_range(0, span / 4);
		low_v = sgn ? {low_raw[31], low_raw} : {1'b0, low_raw};
		high_v = low_v + {1'b0, span / 2} + 33'd1;
		case ($urandom_range(0, 7))
			0: begin
				low_v = 33'h1_0000_0000;
				high_v = 33'h0_FFFF_FFFF;
			end
			1: begin
				low_v = high_v;
				high_v = low_v - {1'b0, span / 2} - 33'd1;
			end
			2: high_v = low_v;
			default: ;
		endcase
		drain();
		cfg_write(mmcs_pkg::REG_PIX_SGN, {32'd0, sgn});
		cfg_write(mmcs_pkg::REG_OVR_EN, 33'($urandom_range(0, 3) == 0));
		cfg_write(mmcs_pkg::REG_OVR_LOW, low_v);
		cfg_write(mmcs_pkg::REG_OVR_HIGH, high_v);
		cfg_write(mmcs_pkg::REG_IGN_EN, 33'($urandom_range(0, 2) == 0));
		cfg_write(mmcs_pkg::REG_IGN_LVL, sgn ? {ign_raw[31], ign_raw} : {1'b0, ign_raw});
	endtask

	// one frame: statistics pass then scale pass, sometimes deliberately malformed
	task automatic run_frame();
		int n;
		int shape;
		int reps;
		logic [31:0] v;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
		shape = $urandom_range(0, 11);
		// shape 0: no last marker, 1: no scale pass, 2: scale twice,
		// 3: random last markers, 4: scale pass only
		if (shape != 4) begin
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3: v = ign_raw;
					4: v = $urandom;
					default: v = base + $urandom_range(0, span);
				endcase
				push_word(1'b0, v, (i == n - 1) && shape != 0);
			end
		end
		if (shape == 1)
			return;
		reps = (shape == 2) ? 2 : 1;
		for (int r = 0; r < reps; r++) begin
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 9))
					0: v = base - $urandom_range(1, 1000);
					1: v = base + span + $urandom_range(1, 1000);
					2: v = $urandom;
					default: v = base + $urandom_range(0, span);
				endcase
				push_word(1'b1, v, (shape == 3) ? 1'($urandom_range(0, 1)) : (i == n - 1));
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// scale before any statistics: reset bounds are inverted, so flat
		push_word(1'b1, 32'h0000_0000, 1'b1);
		// signed extremes
		push_word(1'b0, 32'h8000_0000, 1'b0);
		push_word(1'b0, 32'h7FFF_FFFF, 1'b0);
		push_word(1'b0, 32'hFFFF_FFFF, 1'b0);
		push_word(1'b0, 32'h0000_0000, 1'b1);
		push_word(1'b1, 32'h8000_0000, 1'b0);
		push_word(1'b1, 32'h7FFF_FFFF, 1'b0);
		push_word(1'b1, 32'hFFFF_FFFF, 1'b0);
		push_word(1'b1, 32'h0000_0001, 1'b1);

		// every pixel ignored, then a flat frame
		drain();
		cfg_write(mmcs_pkg::REG_IGN_EN, 33'd1);
		cfg_write(mmcs_pkg::REG_IGN_LVL, 33'd5);
		push_word(1'b0, 32'd5, 1'b0);
		push_word(1'b0, 32'd5, 1'b1);
		push_word(1'b1, 32'd5, 1'b1);
		push_word(1'b0, 32'd7, 1'b0);
		push_word(1'b0, 32'd7, 1'b1);
		push_word(1'b1, 32'd7, 1'b1);

		// fixed bounds, unsigned pixels, clamping on both sides
		drain();
		cfg_write(mmcs_pkg::REG_IGN_EN, 33'd0);
		cfg_write(mmcs_pkg::REG_PIX_SGN, 33'd0);
		cfg_write(mmcs_pkg::REG_OVR_EN, 33'd1);
		cfg_write(mmcs_pkg::REG_OVR_LOW, 33'd100);
		cfg_write(mmcs_pkg::REG_OVR_HIGH, 33'd355);
		push_word(1'b0, 32'hFFFF_FFFF, 1'b0);
		push_word(1'b0, 32'h0000_0000, 1'b1);
		push_word(1'b1, 32'd50, 1'b0);
		push_word(1'b1, 32'd400, 1'b0);
		push_word(1'b1, 32'd100, 1'b0);
		push_word(1'b1, 32'd354, 1'b0);
		push_word(1'b1, 32'hFFFF_FFFF, 1'b1);

		// widest register bounds, then inverted bounds
		drain();
		cfg_write(mmcs_pkg::REG_OVR_LOW, 33'h1_0000_0000);
		cfg_write(mmcs_pkg::REG_OVR_HIGH, 33'h0_FFFF_FFFF);
		push_word(1'b1, 32'hFFFF_FFFF, 1'b0);
		push_word(1'b1, 32'h0000_0000, 1'b1);
		drain();
		cfg_write(mmcs_pkg::REG_OVR_LOW, 33'd300);
		cfg_write(mmcs_pkg::REG_OVR_HIGH, 33'd200);
		push_word(1'b1, 32'd250, 1'b1);

		// random frames
		words_sent = 0;
		while (words_sent < 1250) begin
			if (words_sent == 0 || $urandom_range(0, 1) == 0)
				new_setting();
			run_frame();
		end

		drain();
		if (chk.fails == 0 && chk.due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
